FILE: hw/rtl/first_substring_match_index_unit_defines.svh
// assertion macros for the substring match unit
// expects clk and rst_n in the scope where a macro is used
`ifndef FIRST_SUBSTRING_MATCH_INDEX_UNIT_DEFINES_SVH
`define FIRST_SUBSTRING_MATCH_INDEX_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define FSMI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define FSMI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/fsmi_pkg.sv
// shared constants and types for the substring match unit
// no dependencies
`default_nettype none

package fsmi_pkg;

    // sizing
    localparam int MAX_PATTERN = 32;
    localparam int MAX_TEXT    = 256;
    localparam int CHAR_W      = 8;
    localparam int MATCH_W     = 9;
    localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int PLEN_W      = $clog2(MAX_PATTERN + 1);
    localparam int TPOS_W      = $clog2(MAX_TEXT + 1);
    localparam int CALC_W      = (TPOS_W > MATCH_W) ? TPOS_W : MATCH_W;

    // stream word widths
    localparam int S_DATA_W = 8;
    localparam int S_USER_W = 1;
    localparam int M_DATA_W = 16;

    // reported when the pattern never occurs
    localparam logic [MATCH_W-1:0] MATCH_NONE = '1;

    // kind of input word
    typedef enum logic
    {
        OP_PATTERN = 1'b0,
        OP_TEXT    = 1'b1
    } op_t;

    // per-cycle commands broadcast along the cell chain
    typedef struct packed
    {
        logic              load;
        logic              step;
        logic              clear;
        logic [IDX_W-1:0]  load_idx;
        logic [CHAR_W-1:0] ch;
    } cell_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/first_substring_match_index_unit.sv
// top level of the streaming substring match unit
// depends on fsmi_pkg, fsmi_chain and first_substring_match_index_unit_defines.svh
//
// Usage: input words arrive on s_axis. tuser[0] selects pattern (0) or text (1),
// tdata[7:0] is the character, tlast ends the pattern or the text. A pattern of
// up to 32 characters is loaded first; a pattern word after a finished pattern
// starts a new one. Text words then stream through a row of 32 comparison cells.
// Text arriving before a pattern is finished is dropped without a result.
// On the last text word one result word leaves on m_axis: tdata[8:0] is the
// first start index of the pattern (0x1FF when absent), tdata[9] flags that the
// pattern or the text (over 256 characters) was cut short.
// Throughput: one input word per cycle unless a held result stalls the input,
// set by the cell row, which compares all cells with the new character at once.
// Latency: the result word is valid the cycle after its last text word.
// Reset clears the cells, lengths, flags and the output valid bit; the stored
// pattern characters are left as they were and are reloaded before use.
// A stalled receiver holds the result in the output register; input is taken
// in the same cycle the held result is taken, and waits otherwise.
`default_nettype none
`include "first_substring_match_index_unit_defines.svh"

module first_substring_match_index_unit
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [fsmi_pkg::S_DATA_W-1:0] s_axis_tdata,  // char_value
    input  wire logic [fsmi_pkg::S_USER_W-1:0] s_axis_tuser,  // operation
    input  wire logic                          s_axis_tlast,  // last
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [fsmi_pkg::M_DATA_W-1:0]      m_axis_tdata   // match_position, overflow
);

    import fsmi_pkg::*;

    logic [PLEN_W-1:0]   plen_reg;
    logic [PLEN_W-1:0]   plen_next;
    logic                complete_reg;
    logic                complete_next;
    logic [TPOS_W-1:0]   tpos_reg;
    logic [TPOS_W-1:0]   tpos_next;
    logic                found_reg;
    logic                found_next;
    logic [MATCH_W-1:0]  fpos_reg;
    logic [MATCH_W-1:0]  fpos_next;
    logic                ovf_reg;
    logic                ovf_next;
    logic                m_valid_reg;
    logic                m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg;
    logic [M_DATA_W-1:0] m_data_next;

    logic                accept;
    logic                pat_acc;
    logic                txt_acc;
    logic [PLEN_W-1:0]   base;
    logic                room;
    logic                in_range;
    logic                hit;
    logic [CALC_W-1:0]   pos_calc;
    logic [MATCH_W-1:0]  result_pos;
    logic                result_ovf;
    op_t                 op;
    cell_ctl_t           ctl;

    // input handshake, output register decouples the two sides
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign op            = op_t'(s_axis_tuser[0]);
    assign pat_acc       = accept && (op == OP_PATTERN);
    assign txt_acc       = accept && (op == OP_TEXT) && complete_reg;

    // a finished pattern is restarted by its next pattern word
    assign base     = complete_reg ? '0 : plen_reg;
    assign room     = base < PLEN_W'(MAX_PATTERN);
    assign in_range = tpos_reg < TPOS_W'(MAX_TEXT);

    // commands to the cell row
    always_comb
    begin
        ctl.load     = pat_acc && room;
        ctl.step     = txt_acc && in_range;
        ctl.clear    = (pat_acc && complete_reg) || (txt_acc && s_axis_tlast);
        ctl.load_idx = base[IDX_W-1:0];
        ctl.ch       = s_axis_tdata[CHAR_W-1:0];
    end

    fsmi_chain u_chain
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .hit   (hit)
    );

    // start index of a match ending at this character
    assign pos_calc = CALC_W'(tpos_reg) + CALC_W'(1) - CALC_W'(plen_reg);

    always_comb
    begin
        if (found_reg)
        begin
            result_pos = fpos_reg;
        end
        else if (hit)
        begin
            result_pos = pos_calc[MATCH_W-1:0];
        end
        else
        begin
            result_pos = MATCH_NONE;
        end
    end

    assign result_ovf = ovf_reg || (txt_acc && !in_range);

    // pattern and text bookkeeping
    always_comb
    begin
        plen_next     = plen_reg;
        complete_next = complete_reg;
        tpos_next     = tpos_reg;
        found_next    = found_reg;
        fpos_next     = fpos_reg;
        ovf_next      = ovf_reg;

        if (pat_acc)
        begin
            plen_next     = room ? PLEN_W'(base + PLEN_W'(1)) : base;
            complete_next = s_axis_tlast;
            ovf_next      = (complete_reg ? 1'b0 : ovf_reg) || !room;
            if (complete_reg)
            begin
                tpos_next  = '0;
                found_next = 1'b0;
                fpos_next  = '0;
            end
        end
        else if (txt_acc)
        begin
            ovf_next = result_ovf;
            if (s_axis_tlast)
            begin
                tpos_next  = '0;
                found_next = 1'b0;
                fpos_next  = '0;
            end
            else if (in_range)
            begin
                tpos_next  = TPOS_W'(tpos_reg + TPOS_W'(1));
                found_next = found_reg || hit;
                if (hit && !found_reg)
                begin
                    fpos_next = pos_calc[MATCH_W-1:0];
                end
            end
        end
    end

    // output register
    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (txt_acc && s_axis_tlast)
        begin
            m_valid_next = 1'b1;
            m_data_next  = M_DATA_W'({result_ovf, result_pos});
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg     <= '0;
            complete_reg <= 1'b0;
            tpos_reg     <= '0;
            found_reg    <= 1'b0;
            fpos_reg     <= '0;
            ovf_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            plen_reg     <= plen_next;
            complete_reg <= complete_next;
            tpos_reg     <= tpos_next;
            found_reg    <= found_next;
            fpos_reg     <= fpos_next;
            ovf_reg      <= ovf_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // checks
    `FSMI_ASSERT_NEXT(a_result_after_last, txt_acc && s_axis_tlast, m_axis_tvalid, "no result after last text word")
    `FSMI_ASSERT_NOW(a_hit_needs_step, hit, ctl.step, "cell hit without a text step")
    `FSMI_ASSERT_NOW(a_found_order, found_reg, CALC_W'(tpos_reg) >= CALC_W'(plen_reg), "found match precedes pattern length")

endmodule

`default_nettype wire

FILE: hw/rtl/fsmi_cell.sv
// one comparison cell: a stored pattern character and its partial-match bit
// depends on fsmi_pkg
`default_nettype none

module fsmi_cell
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire fsmi_pkg::cell_ctl_t ctl,
    input  wire logic               sel,
    input  wire logic               prev_match,
    output logic                    match,
    output logic                    hit
);

    import fsmi_pkg::*;

    logic [CHAR_W-1:0] char_reg;
    logic              tail_reg;
    logic              tail_next;
    logic              match_reg;
    logic              match_next;
    logic              extend;

    // prefix ending here grows when the neighbor matched and this character agrees
    assign extend = prev_match && (char_reg == ctl.ch);

    always_comb
    begin
        match_next = match_reg;
        if (ctl.clear)
        begin
            match_next = 1'b0;
        end
        else if (ctl.step)
        begin
            match_next = extend;
        end
    end

    // tail marks the last stored pattern character
    always_comb
    begin
        tail_next = tail_reg;
        if (ctl.load)
        begin
            tail_next = sel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
            tail_reg  <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
            tail_reg  <= tail_next;
        end
    end

    // character store, written once per pattern load
    always_ff @(posedge clk)
    begin
        if (ctl.load && sel)
        begin
            char_reg <= ctl.ch;
        end
    end

    assign match = match_reg;
    assign hit   = ctl.step && extend && tail_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/fsmi_chain.sv
// row of comparison cells, each passing its match bit to the next
// depends on fsmi_pkg and fsmi_cell
`default_nettype none

module fsmi_chain
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire fsmi_pkg::cell_ctl_t ctl,
    output logic                     hit
);

    import fsmi_pkg::*;

    logic [MAX_PATTERN-1:0] match;
    logic [MAX_PATTERN-1:0] prev;
    logic [MAX_PATTERN-1:0] sel;
    logic [MAX_PATTERN-1:0] hits;

    // cell 0 always sees a matched empty prefix
    assign prev[0] = 1'b1;

    genvar k;
    generate
        for (k = 0; k < MAX_PATTERN; k++)
        begin : g_cell
            if (k > 0)
            begin : g_link
                assign prev[k] = match[k-1];
            end

            assign sel[k] = (ctl.load_idx == IDX_W'(k));

            fsmi_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .sel        (sel[k]),
                .prev_match (prev[k]),
                .match      (match[k]),
                .hit        (hits[k])
            );
        end
    endgenerate

    // only the tail cell can report a full match
    assign hit = |hits;

endmodule

`default_nettype wire

FILE: test/tb_first_substring_match_index_unit.sv
// self-checking testbench for first_substring_match_index_unit
// predicts every search result in the bench and checks it on m_axis
// depends on fsmi_pkg and the unit's rtl

module tb_first_substring_match_index_unit;

    import fsmi_pkg::*;

    localparam int      CLK_HALF   = 10;
    localparam longint  LIMIT_TIME = 64'd4_000_000;
    localparam int      SETTLE_CYC = 8;

    // one input word: character, pattern/text selector, end marker
    typedef struct packed
    {
        op_t               op;
        logic [CHAR_W-1:0] ch;
        logic              last;
    } char_word_t;

    // one result word
    typedef struct packed
    {
        logic [MATCH_W-1:0] pos;
        logic               ovf;
    } match_result_t;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;
    logic [S_USER_W-1:0] s_axis_tuser  = '0;
    logic                s_axis_tlast  = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;

    first_substring_match_index_unit DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // words waiting to be sent and search results still due
    char_word_t    char_words_pending[$];
    match_result_t match_results_due[$];

    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int words_queued = 0;
    int words_taken  = 0;
    int fail_count   = 0;
    int result_count = 0;
    int found_count  = 0;
    int ovf_count    = 0;

    // search state mirrored in the bench
    logic [CHAR_W-1:0]      pat_mem [MAX_PATTERN];
    int unsigned            pat_len     = 0;
    bit                     pat_done    = 1'b0;
    bit [MAX_PATTERN-1:0]   prefix_hits = '0;
    int unsigned            txt_pos     = 0;
    bit                     hit_seen    = 1'b0;
    int unsigned            hit_pos     = 0;
    bit                     ovf_seen    = 1'b0;

    function automatic void clear_search();
        prefix_hits = '0;
        txt_pos     = 0;
        hit_seen    = 1'b0;
        hit_pos     = 0;
    endfunction

    // advance the mirrored search by one word; returns 1 when a result is due
    function automatic bit predict_match(input char_word_t w, output match_result_t res);
        int unsigned len;
        bit          prev;
        res = '0;
        if (w.op == OP_PATTERN)
        begin
            // a pattern word after a finished pattern starts over
            if (pat_done)
            begin
                pat_len  = 0;
                pat_done = 1'b0;
                ovf_seen = 1'b0;
                clear_search();
            end
            if (pat_len < MAX_PATTERN)
            begin
                pat_mem[pat_len] = w.ch;
                pat_len++;
            end
            else
                ovf_seen = 1'b1;
            if (w.last)
                pat_done = 1'b1;
            return 1'b0;
        end
        // text before the pattern is finished is dropped
        if (!pat_done)
            return 1'b0;
        if (txt_pos >= MAX_TEXT)
            ovf_seen = 1'b1;
        else
        begin
            len = pat_len;
            // walk the cells from the far end so each reads its old neighbor
            for (int i = len; i > 0; i--)
            begin
                prev = (i == 1) ? 1'b1 : prefix_hits[i-2];
                prefix_hits[i-1] = prev && (pat_mem[i-1] == w.ch);
            end
            if (len > 0 && prefix_hits[len-1] && !hit_seen)
            begin
                hit_seen = 1'b1;
                hit_pos  = txt_pos + 1 - len;
            end
            txt_pos++;
        end
        if (!w.last)
            return 1'b0;
        res.pos = hit_seen ? hit_pos[MATCH_W-1:0] : MATCH_NONE;
        res.ovf = ovf_seen;
        clear_search();
        return 1'b1;
    endfunction

    // driver: sender and receiver with random idle cycles
    char_word_t next_word;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
            s_axis_tlast  <= 1'b0;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (char_words_pending.size() != 0 && $urandom_range(99) >= snd_idle_pct)
                begin
                    next_word = char_words_pending.pop_front();
                    s_axis_tdata  <= next_word.ch;
                    s_axis_tuser  <= next_word.op;
                    s_axis_tlast  <= next_word.last;
                    s_axis_tvalid <= 1'b1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor: check results, then predict from the accepted input word
    match_result_t due_res;
    match_result_t new_res;
    char_word_t    seen_word;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                result_count++;
                if (match_results_due.size() == 0)
                begin
                    $error("result word 0x%0h with no result due", m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    due_res = match_results_due.pop_front();
                    if (due_res.pos != MATCH_NONE)
                        found_count++;
                    if (due_res.ovf)
                        ovf_count++;
                    if (m_axis_tdata[MATCH_W-1:0] !== due_res.pos)
                    begin
                        $error("match_position: expected %0d, actual %0d",
                               $signed(due_res.pos), $signed(m_axis_tdata[MATCH_W-1:0]));
                        fail_count++;
                    end
                    if (m_axis_tdata[MATCH_W] !== due_res.ovf)
                    begin
                        $error("overflow: expected %0b, actual %0b",
                               due_res.ovf, m_axis_tdata[MATCH_W]);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                words_taken++;
                seen_word.op   = op_t'(s_axis_tuser[0]);
                seen_word.ch   = s_axis_tdata;
                seen_word.last = s_axis_tlast;
                if (predict_match(seen_word, new_res))
                    match_results_due.push_back(new_res);
            end
        end
    end

    // stimulus side: what the generator believes the loaded pattern is
    logic [CHAR_W-1:0] gen_pat [MAX_PATTERN];
    int                gen_plen = 0;
    logic [CHAR_W-1:0] alpha [3];
    bit                narrow   = 1'b0;

    task automatic push_word(input op_t op, input logic [CHAR_W-1:0] ch, input bit last);
        char_word_t w;
        w.op   = op;
        w.ch   = ch;
        w.last = last;
        char_words_pending.push_back(w);
        words_queued++;
    endtask

    // small alphabets make matches likely, full range covers every bit
    function automatic logic [CHAR_W-1:0] pick_char();
        if (narrow)
            return alpha[$urandom_range(2)];
        return CHAR_W'($urandom_range(255, 1));
    endfunction

    // load a pattern; a broken one of two or more characters has text words in its middle
    task automatic load_pattern(input int n, input bit broken);
        logic [CHAR_W-1:0] c;
        narrow = ($urandom_range(9) < 7);
        for (int a = 0; a < 3; a++)
            alpha[a] = CHAR_W'($urandom_range(255, 1));
        for (int i = 0; i < n; i++)
        begin
            if (broken && i > 0 && i == n / 2)
            begin
                repeat ($urandom_range(3, 1))
                    push_word(OP_TEXT, pick_char(), 1'($urandom_range(1)));
            end
            c = pick_char();
            if (i < MAX_PATTERN)
                gen_pat[i] = c;
            push_word(OP_PATTERN, c, i == n - 1);
        end
        gen_plen = (n < MAX_PATTERN) ? n : MAX_PATTERN;
    endtask

    // send one text, half the time with the pattern planted in it if it fits
    task automatic send_text(input int n);
        logic [CHAR_W-1:0] txt [$];
        int                at;
        for (int i = 0; i < n; i++)
            txt.push_back(pick_char());
        if ($urandom_range(1) && gen_plen <= n)
        begin
            at = $urandom_range(n - gen_plen);
            for (int j = 0; j < gen_plen; j++)
                txt[at + j] = gen_pat[j];
        end
        for (int i = 0; i < n; i++)
            push_word(OP_TEXT, txt[i], i == n - 1);
    endtask

    // hold the sender until every word is in and every result is out
    task automatic drain_all();
        while (char_words_pending.size() != 0 || s_axis_tvalid ||
               match_results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(input int words, input int snd, input int rcv);
        int start;
        int r;
        int p;
        int plen;
        snd_idle_pct = snd;
        rcv_idle_pct = rcv;
        start = words_queued;
        // one text around the length limit per phase
        load_pattern($urandom_range(3, 1), 1'b0);
        send_text($urandom_range(260, 254));
        while (words_queued - start < words)
        begin
            r = $urandom_range(99);
            if (r < 18)
            begin
                p = $urandom_range(99);
                if (p < 80)
                    plen = $urandom_range(4, 1);
                else if (p < 93)
                    plen = $urandom_range(32, 5);
                else
                    plen = $urandom_range(40, 33);
                load_pattern(plen, r < 4);
            end
            if ($urandom_range(9) == 0)
                send_text($urandom_range(60, 25));
            else
                send_text($urandom_range(24, 1));
        end
        drain_all();
    endtask

    // main sequence
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // text before any pattern is dropped
        push_word(OP_TEXT, 8'h41, 1'b1);
        // two-character pattern at the byte extremes
        push_word(OP_PATTERN, 8'hFF, 1'b0);
        push_word(OP_PATTERN, 8'h01, 1'b1);
        // match at the very start
        push_word(OP_TEXT, 8'hFF, 1'b0);
        push_word(OP_TEXT, 8'h01, 1'b1);
        // no match
        push_word(OP_TEXT, 8'h80, 1'b0);
        push_word(OP_TEXT, 8'h7F, 1'b1);
        // match one position in
        push_word(OP_TEXT, 8'h01, 1'b0);
        push_word(OP_TEXT, 8'hFF, 1'b0);
        push_word(OP_TEXT, 8'h01, 1'b1);
        // text shorter than the pattern cannot match
        push_word(OP_TEXT, 8'hFF, 1'b1);
        // single-character pattern
        push_word(OP_PATTERN, 8'h55, 1'b1);
        push_word(OP_TEXT, 8'hAA, 1'b0);
        push_word(OP_TEXT, 8'h55, 1'b1);
        // new pattern in the middle of a text restarts the search
        push_word(OP_TEXT, 8'h55, 1'b0);
        push_word(OP_PATTERN, 8'h41, 1'b1);
        push_word(OP_TEXT, 8'h41, 1'b1);
        // pattern cut off mid-way by a text word, which is dropped
        push_word(OP_PATTERN, 8'h33, 1'b0);
        push_word(OP_TEXT, 8'h33, 1'b1);
        push_word(OP_PATTERN, 8'hCC, 1'b1);
        push_word(OP_TEXT, 8'h33, 1'b0);
        push_word(OP_TEXT, 8'hCC, 1'b1);
        drain_all();

        run_phase(630, 8, 67);
        run_phase(630, 67, 8);
        run_phase(630, 0, 0);

        repeat (SETTLE_CYC) @(posedge clk);
        $display("sent %0d words (%0d queued), checked %0d search results",
                 words_taken, words_queued, result_count);
        $display("%0d results found the pattern, %0d reported overflow",
                 found_count, ovf_count);
        if (fail_count == 0 && match_results_due.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // watchdog
    initial
    begin
        #(LIMIT_TIME);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
